// ----- hw/rtl/drmg_pkg.sv -----
// Package for the dial region mask generator: shared widths, mode and
// register index codes, packed register layouts and the squared-difference helper.
// No dependencies.
package drmg_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned RADIUS_BASE_W  = FIELD_W + 1;
  localparam int unsigned DIFF_W         = FIELD_W + 2;
  localparam int unsigned SQ_W           = 2 * FIELD_W;
  localparam int unsigned DIST_W         = SQ_W + 1;

  typedef enum logic [2:0] {
    MODE_FULL         = 3'd0,
    MODE_DISK         = 3'd1,
    MODE_DISK_RECT1   = 3'd2,
    MODE_DISK_RECT2   = 3'd3,
    MODE_DISK_RECT3   = 3'd4,
    MODE_ANNULUS      = 3'd5,
    MODE_ANNULUS_RECT = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_MODE    = 3'd0,
    REG_OUTER_CIRCLE = 3'd1,
    REG_INNER_CIRCLE = 3'd2,
    REG_RECT_FIRST   = 3'd3,
    REG_RECT_SECOND  = 3'd4,
    REG_RECT_THIRD   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [FIELD_W-1:0] r;
    logic [FIELD_W-1:0] cy;
    logic [FIELD_W-1:0] cx;
  } circle_t;

  typedef struct packed {
    logic [FIELD_W-1:0] y1;
    logic [FIELD_W-1:0] x1;
    logic [FIELD_W-1:0] y0;
    logic [FIELD_W-1:0] x0;
  } box_t;

  // Geometry derived from the registers, as the datapath consumes it.
  typedef struct packed {
    mode_e              mode;
    logic [FIELD_W-1:0] ocx;
    logic [FIELD_W-1:0] ocy;
    logic [FIELD_W-1:0] icx;
    logic [FIELD_W-1:0] icy;
    logic [DIST_W-1:0]  lim_o;
    logic [DIST_W-1:0]  lim_i;
    box_t               b1;
    box_t               b2;
    box_t               b3;
  } geom_t;

  // Squares and rectangle hits of one pixel, handed to the final stage.
  typedef struct packed {
    logic [SQ_W-1:0] sq_ox;
    logic [SQ_W-1:0] sq_oy;
    logic [SQ_W-1:0] sq_ix;
    logic [SQ_W-1:0] sq_iy;
    logic            hit_b1;
    logic            hit_b2;
    logic            hit_b3;
    logic            hit_s1;
  } sq_word_t;

  function automatic logic signed [DIFF_W-1:0] sext_field(logic [FIELD_W-1:0] v);
    return $signed({{(DIFF_W-FIELD_W){v[FIELD_W-1]}}, v});
  endfunction

  function automatic logic [SQ_W-1:0] sq_diff(logic signed [DIFF_W-1:0] a,
                                              logic signed [DIFF_W-1:0] b);
    logic signed [DIFF_W-1:0]   d;
    logic signed [2*DIFF_W-1:0] p;
    d = a - b;
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/drmg_cfg.sv -----
// Configuration registers of the dial region mask generator and the geometry
// derived from them (circle order, squared radius limits). Depends on drmg_pkg.
module drmg_cfg import drmg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output geom_t                 geom_o
);

  mode_e           mode_q;
  circle_t         outer_q;
  circle_t         inner_q;
  box_t            rect1_q;
  box_t            rect2_q;
  box_t            rect3_q;
  geom_t           geom_d;
  geom_t           geom_q;

  circle_t                  co;
  circle_t                  ci;
  logic                     swap;
  logic                     strict;
  logic [RADIUS_BASE_W-1:0] base_o;
  logic [RADIUS_BASE_W-1:0] base_i;
  logic [2*RADIUS_BASE_W-1:0] prod_o;
  logic [2*RADIUS_BASE_W-1:0] prod_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FULL;
      outer_q <= '0;
      inner_q <= '0;
      rect1_q <= '0;
      rect2_q <= '0;
      rect3_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MASK_MODE:    mode_q  <= mode_e'(cfg_data_i[2:0]);
        REG_OUTER_CIRCLE: outer_q <= circle_t'(cfg_data_i[$bits(circle_t)-1:0]);
        REG_INNER_CIRCLE: inner_q <= circle_t'(cfg_data_i[$bits(circle_t)-1:0]);
        REG_RECT_FIRST:   rect1_q <= box_t'(cfg_data_i);
        REG_RECT_SECOND:  rect2_q <= box_t'(cfg_data_i);
        REG_RECT_THIRD:   rect3_q <= box_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // In the annulus modes the larger circle is the outer one. The strict
  // annulus mode compares against r*r outside and (r+1)^2 inside.
  always_comb begin
    swap   = (mode_q == MODE_ANNULUS || mode_q == MODE_ANNULUS_RECT) &&
             (outer_q.r < inner_q.r);
    strict = (mode_q == MODE_ANNULUS_RECT);
    co     = swap ? inner_q : outer_q;
    ci     = swap ? outer_q : inner_q;
    base_o = strict ? {1'b0, co.r} : ({1'b0, co.r} + RADIUS_BASE_W'(1));
    base_i = strict ? ({1'b0, ci.r} + RADIUS_BASE_W'(1)) : {1'b0, ci.r};
    prod_o = base_o * base_o;
    prod_i = base_i * base_i;

    geom_d       = geom_q;
    geom_d.mode  = mode_q;
    geom_d.ocx   = co.cx;
    geom_d.ocy   = co.cy;
    geom_d.icx   = ci.cx;
    geom_d.icy   = ci.cy;
    geom_d.lim_o = prod_o[DIST_W-1:0];
    geom_d.lim_i = prod_i[DIST_W-1:0];
    geom_d.b1    = rect1_q;
    geom_d.b2    = rect2_q;
    geom_d.b3    = rect3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= '0;
    end else begin
      geom_q <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

// ----- hw/rtl/drmg_front.sv -----
// Input register and first datapath stage: squared coordinate differences to
// both circle centers and rectangle membership flags. Depends on drmg_pkg.
module drmg_front import drmg_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  in_load_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  sq_load_i,
  input  geom_t                 geom_i,
  output sq_word_t              sq_o
);

  logic [COORD_BITS-1:0]    x_q;
  logic [COORD_BITS-1:0]    y_q;
  logic signed [DIFF_W-1:0] xs;
  logic signed [DIFF_W-1:0] ys;
  sq_word_t                 sq_d;
  sq_word_t                 sq_q;

  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
  end

  always_comb begin
    xs = $signed({{(DIFF_W-COORD_BITS){1'b0}}, x_q});
    ys = $signed({{(DIFF_W-COORD_BITS){1'b0}}, y_q});

    sq_d.sq_ox = sq_diff(xs, sext_field(geom_i.ocx));
    sq_d.sq_oy = sq_diff(ys, sext_field(geom_i.ocy));
    sq_d.sq_ix = sq_diff(xs, sext_field(geom_i.icx));
    sq_d.sq_iy = sq_diff(ys, sext_field(geom_i.icy));

    sq_d.hit_b1 = xs >= sext_field(geom_i.b1.x0) && xs <= sext_field(geom_i.b1.x1) &&
                  ys >= sext_field(geom_i.b1.y0) && ys <= sext_field(geom_i.b1.y1);
    sq_d.hit_b2 = xs >= sext_field(geom_i.b2.x0) && xs <= sext_field(geom_i.b2.x1) &&
                  ys >= sext_field(geom_i.b2.y0) && ys <= sext_field(geom_i.b2.y1);
    sq_d.hit_b3 = xs >= sext_field(geom_i.b3.x0) && xs <= sext_field(geom_i.b3.x1) &&
                  ys >= sext_field(geom_i.b3.y0) && ys <= sext_field(geom_i.b3.y1);
    sq_d.hit_s1 = xs > sext_field(geom_i.b1.x0) && xs < sext_field(geom_i.b1.x1) &&
                  ys > sext_field(geom_i.b1.y0) && ys < sext_field(geom_i.b1.y1);
  end

  always_ff @(posedge clk_i) begin
    if (sq_load_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- hw/rtl/drmg_decide.sv -----
// Final stage: sums squared distances, compares them with the radius limits
// and applies the mask mode into the result register. Depends on drmg_pkg.
module drmg_decide import drmg_pkg::*; (
  input  logic     clk_i,
  input  logic     res_load_i,
  input  sq_word_t sq_i,
  input  geom_t    geom_i,
  output logic     in_region_o
);

  logic [DIST_W-1:0] dist_o;
  logic [DIST_W-1:0] dist_i;
  logic              in_outer;
  logic              out_inner;
  logic              keep_d;
  logic              keep_q;

  always_comb begin
    dist_o    = {1'b0, sq_i.sq_ox} + {1'b0, sq_i.sq_oy};
    dist_i    = {1'b0, sq_i.sq_ix} + {1'b0, sq_i.sq_iy};
    in_outer  = dist_o < geom_i.lim_o;
    out_inner = dist_i >= geom_i.lim_i;

    unique case (geom_i.mode)
      MODE_FULL:         keep_d = 1'b1;
      MODE_DISK:         keep_d = in_outer;
      MODE_DISK_RECT1:   keep_d = in_outer && !sq_i.hit_b1;
      MODE_DISK_RECT2:   keep_d = in_outer && !sq_i.hit_b1 && !sq_i.hit_b2;
      MODE_DISK_RECT3:   keep_d = in_outer && !sq_i.hit_b1 && !sq_i.hit_b2 &&
                                  !sq_i.hit_b3;
      MODE_ANNULUS:      keep_d = in_outer && out_inner;
      MODE_ANNULUS_RECT: keep_d = in_outer && out_inner && !sq_i.hit_s1;
      default:           keep_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_load_i) begin
      keep_q <= keep_d;
    end
  end

  assign in_region_o = keep_q;

endmodule

// ----- hw/rtl/dial_region_mask_generator_unit.sv -----
// Top level of the dial region mask generator: pipeline control and the
// three datapath parts. Depends on drmg_pkg, drmg_cfg, drmg_front, drmg_decide.
//
//   channel  | direction | handshake              | word
//   ---------+-----------+------------------------+-----------------------------
//   in       | input     | in_valid_i/in_stall_o  | pixel_x_i, pixel_y_i
//   out      | output    | out_valid_o/out_stall_i| in_region_o
//   cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word is accepted every cycle while in_stall_o is low.
// The stages are the input register, the squares register and the result register.
// The configuration port is always ready; derived geometry is registered after a write.
// Reset clears the configuration and all stage valid flags; data registers are not reset.
// A stall on the output only backs up the input once all three stages are full.
module dial_region_mask_generator_unit import drmg_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  in_region_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  geom_t    geom;
  sq_word_t sq;
  logic     v1_q, v2_q, v3_q;
  logic     rdy1, rdy2, rdy3;

  always_comb begin
    rdy3 = !v3_q || !out_stall_i;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  drmg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  drmg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .in_load_i (in_valid_i && rdy1),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .sq_load_i (v1_q && rdy2),
    .geom_i    (geom),
    .sq_o      (sq)
  );

  drmg_decide u_decide (
    .clk_i       (clk_i),
    .res_load_i  (v2_q && rdy3),
    .sq_i        (sq),
    .geom_i      (geom),
    .in_region_o (in_region_o)
  );

endmodule

// ----- hw/rtl/drmg_checker.sv -----
// Port-level checker for the dial region mask generator and its bind to the
// top level. Depends on the port names of dial_region_mask_generator_unit.
module drmg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic in_region_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  // A stalled result word keeps its valid and its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(in_region_o))
    else $error("stalled result word changed");

  // With no word waiting at the output the input never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

  // An accepted word reaches the output when the output does not stall in between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result word missing after three cycles");

  // The configuration port never holds off a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind dial_region_mask_generator_unit drmg_checker u_drmg_checker (.*);

// ----- tb/sv/drmg_region_checker.sv -----
// Region checker for the dial region mask generator: mirrors the register file,
// predicts in_region for every accepted pixel word and compares results in order.
// Depends on drmg_pkg.
module drmg_region_checker import drmg_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  in_region_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    outstanding_o,
  output int                    errors_o
);

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  region;
  } region_due_t;

  logic [2:0]  mode_q;
  circle_t     outer_q;
  circle_t     inner_q;
  box_t        rect_q [3];
  region_due_t region_due [$];
  int          errors;

  function automatic longint sx(logic [FIELD_W-1:0] v);
    return {{(64-FIELD_W){v[FIELD_W-1]}}, v};
  endfunction

  function automatic longint dist2(circle_t c, longint x, longint y);
    longint dx;
    longint dy;
    dx = x - sx(c.cx);
    dy = y - sx(c.cy);
    return dx * dx + dy * dy;
  endfunction

  function automatic logic in_box(box_t b, longint x, longint y, logic strict);
    longint x0;
    longint y0;
    longint x1;
    longint y1;
    x0 = sx(b.x0);
    y0 = sx(b.y0);
    x1 = sx(b.x1);
    y1 = sx(b.y1);
    if (strict) return x > x0 && x < x1 && y > y0 && y < y1;
    return x >= x0 && x <= x1 && y >= y0 && y <= y1;
  endfunction

  function automatic logic region_of(longint x, longint y);
    circle_t co;
    circle_t ci;
    circle_t tmp;
    longint  d_o;
    longint  d_i;
    longint  ro;
    longint  ri;
    logic    keep;
    co = outer_q;
    ci = inner_q;
    // In the annulus modes the larger circle always bounds the region from outside.
    if ((mode_q == MODE_ANNULUS || mode_q == MODE_ANNULUS_RECT) && ci.r > co.r) begin
      tmp = co;
      co  = ci;
      ci  = tmp;
    end
    d_o = dist2(co, x, y);
    d_i = dist2(ci, x, y);
    ro  = longint'(co.r);
    ri  = longint'(ci.r);
    case (mode_q)
      MODE_DISK: keep = d_o < (ro + 1) * (ro + 1);
      MODE_DISK_RECT1, MODE_DISK_RECT2, MODE_DISK_RECT3: begin
        keep = d_o < (ro + 1) * (ro + 1) && !in_box(rect_q[0], x, y, 1'b0);
        if (mode_q != MODE_DISK_RECT1) keep = keep && !in_box(rect_q[1], x, y, 1'b0);
        if (mode_q == MODE_DISK_RECT3) keep = keep && !in_box(rect_q[2], x, y, 1'b0);
      end
      MODE_ANNULUS: keep = d_o < (ro + 1) * (ro + 1) && d_i >= ri * ri;
      MODE_ANNULUS_RECT: begin
        keep = d_o < ro * ro && d_i >= (ri + 1) * (ri + 1) && !in_box(rect_q[0], x, y, 1'b1);
      end
      default: keep = 1'b1;
    endcase
    return keep;
  endfunction

  task automatic note_error(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    region_due_t due;
    if (!rst_ni) begin
      mode_q  = '0;
      outer_q = '0;
      inner_q = '0;
      for (int k = 0; k < 3; k++) rect_q[k] = '0;
      region_due.delete();
      errors = 0;
      outstanding_o <= 0;
      errors_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MASK_MODE:    mode_q    = cfg_data_i[2:0];
          REG_OUTER_CIRCLE: outer_q   = cfg_data_i[$bits(circle_t)-1:0];
          REG_INNER_CIRCLE: inner_q   = cfg_data_i[$bits(circle_t)-1:0];
          REG_RECT_FIRST:   rect_q[0] = cfg_data_i;
          REG_RECT_SECOND:  rect_q[1] = cfg_data_i;
          REG_RECT_THIRD:   rect_q[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (region_due.size() == 0) begin
          note_error($sformatf("in_region word %0b arrived with no pixel pending", in_region_i));
        end else begin
          due = region_due.pop_front();
          if (due.region !== in_region_i) begin
            note_error($sformatf("pixel (%0d,%0d): in_region expected %0b, got %0b",
                                 due.x, due.y, due.region, in_region_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due.x      = pixel_x_i;
        due.y      = pixel_y_i;
        due.region = region_of(longint'(pixel_x_i), longint'(pixel_y_i));
        region_due.insert(region_due.size(), due);
      end
      outstanding_o <= region_due.size();
      errors_o      <= errors;
    end
  end

endmodule

// ----- tb/sv/dial_region_mask_generator_unit_tb.sv -----
// Testbench top for the dial region mask generator: drives configuration words and pixel
// words with random gaps under random output stalls, then reports the verdict.
// Depends on drmg_pkg, dial_region_mask_generator_unit and drmg_region_checker.
module dial_region_mask_generator_unit_tb import drmg_pkg::*; ();

  typedef logic [COORD_BITS_DEF-1:0] coord_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int                   CLK_PERIOD  = 20;
  localparam int                   MAX_CYCLES  = 800_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  coord_t                pixel_x_i;
  coord_t                pixel_y_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  in_region_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    outstanding;
  int                    errors;

  int ocx, ocy, orad, icx, icy, irad;
  int rx0 [3];
  int ry0 [3];
  int rx1 [3];
  int ry1 [3];
  bit calm;

  dial_region_mask_generator_unit #(
    .COORD_BITS (COORD_BITS_DEF)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .in_region_o (in_region_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  drmg_region_checker #(
    .COORD_BITS (COORD_BITS_DEF)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .in_region_i   (in_region_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] circle_word(int cx, int cy, int r);
    return {16'h0, 16'(r), 16'(cy), 16'(cx)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] box_word(int x0, int y0, int x1, int y1);
    return {16'(y1), 16'(x1), 16'(y0), 16'(x0)};
  endfunction

  function automatic int pick_center();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? -32768 : 32767;
    return int'($urandom_range(0, 4400)) - 150;
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 2500);
    endcase
  endfunction

  function automatic longint isqrt(longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 131072;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic pick_rects();
    for (int k = 0; k < 3; k++) begin
      rx0[k] = pick_center();
      ry0[k] = pick_center();
      rx1[k] = rx0[k] + int'($urandom_range(0, 1600)) - 100;
      ry1[k] = ry0[k] + int'($urandom_range(0, 1600)) - 100;
      if ($urandom_range(0, 15) == 0) begin
        rx0[k] = -32768;
        ry0[k] = -32768;
        rx1[k] = 32767;
        ry1[k] = 32767;
      end
    end
  endtask

  // Most pixels land next to a circle or rectangle edge so the compares are hit exactly.
  task automatic choose_pixel(output coord_t px, output coord_t py);
    int     sel, k, pick, e0, e1, s0, s1, e, s;
    bit     horiz;
    longint cx, cy, rr, dx, dy, rem;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if (sel < 35) begin
        cx = ocx;
        cy = ocy;
        rr = orad;
      end else begin
        cx = icx;
        cy = icy;
        rr = irad;
      end
      pick = $urandom_range(0, 2 * rr + 2);
      dx   = longint'(pick) - (rr + 1);
      if ($urandom_range(0, 7) == 0) dx = 0;
      rem = ($urandom_range(0, 1) ? rr * rr : (rr + 1) * (rr + 1)) - dx * dx;
      if (rem < 0) rem = 0;
      pick = $urandom_range(0, 2);
      dy   = isqrt(rem) + longint'(pick) - 1;
      if ($urandom_range(0, 1)) dy = -dy;
      px = coord_t'(cx + dx);
      py = coord_t'(cy + dy);
    end else if (sel < 75) begin
      k     = $urandom_range(0, 2);
      horiz = $urandom_range(0, 1);
      e0    = horiz ? ry0[k] : rx0[k];
      e1    = horiz ? ry1[k] : rx1[k];
      s0    = horiz ? rx0[k] : ry0[k];
      s1    = horiz ? rx1[k] : ry1[k];
      e     = ($urandom_range(0, 1) ? e0 : e1) + int'($urandom_range(0, 2)) - 1;
      s     = s0 - 2 + int'($urandom_range(0, (s1 > s0 ? s1 - s0 : s0 - s1) + 4));
      px    = coord_t'(horiz ? s : e);
      py    = coord_t'(horiz ? e : s);
    end else begin
      px = coord_t'($urandom);
      py = coord_t'($urandom);
    end
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(int x, int y);
    in_valid_i <= 1'b1;
    pixel_x_i  <= coord_t'(x);
    pixel_y_i  <= coord_t'(y);
    do @(posedge clk_i); while (in_stall_o);
    idle_gap(calm ? 0 : gap_len());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_geometry(mode_e m, logic [CFG_DATA_W-1:0] oc, logic [CFG_DATA_W-1:0] ic,
                               logic [CFG_DATA_W-1:0] b1, logic [CFG_DATA_W-1:0] b2,
                               logic [CFG_DATA_W-1:0] b3, bit spare);
    if (spare) begin
      write_reg(REG_SPARE_A, {$urandom, $urandom});
      write_reg(REG_SPARE_B, {$urandom, $urandom});
    end
    write_reg(REG_MASK_MODE, CFG_DATA_W'(m));
    write_reg(REG_OUTER_CIRCLE, oc);
    write_reg(REG_INNER_CIRCLE, ic);
    write_reg(REG_RECT_FIRST, b1);
    write_reg(REG_RECT_SECOND, b2);
    write_reg(REG_RECT_THIRD, b3);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int     run;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (1 + gap_len()) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    int     n_items;
    coord_t px, py;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    pixel_x_i   <= '0;
    pixel_y_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    calm        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state is the full frame.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    settle();

    load_geometry(MODE_DISK, circle_word(100, 100, 10), circle_word(0, 0, 0),
                  '0, '0, '0, 1'b1);
    send_pixel(110, 100);
    send_pixel(111, 100);
    send_pixel(100, 89);
    settle();

    load_geometry(MODE_DISK_RECT1, circle_word(100, 100, 10), circle_word(0, 0, 0),
                  box_word(95, 95, 105, 105), '0, '0, 1'b0);
    send_pixel(95, 100);
    send_pixel(94, 100);
    settle();

    load_geometry(MODE_DISK_RECT2, circle_word(100, 100, 10), circle_word(0, 0, 0),
                  box_word(95, 95, 105, 105), box_word(90, 90, 92, 110), '0, 1'b0);
    send_pixel(91, 100);
    settle();

    // An inverted first rectangle excludes nothing.
    load_geometry(MODE_DISK_RECT3, circle_word(2000, 2000, 3000), circle_word(0, 0, 0),
                  box_word(10, 10, 5, 20), box_word(0, 0, 4095, 0),
                  box_word(4095, 4095, 4095, 4095), 1'b0);
    send_pixel(7, 15);
    send_pixel(300, 0);
    send_pixel(4095, 4095);
    settle();

    // Inner radius larger than outer: the circles trade places.
    load_geometry(MODE_ANNULUS, circle_word(100, 100, 5), circle_word(100, 100, 10),
                  '0, '0, '0, 1'b0);
    send_pixel(100, 105);
    send_pixel(100, 104);
    send_pixel(100, 111);
    settle();

    load_geometry(MODE_ANNULUS_RECT, circle_word(100, 100, 10), circle_word(100, 100, 3),
                  box_word(95, 95, 105, 105), '0, '0, 1'b0);
    send_pixel(100, 110);
    send_pixel(100, 109);
    send_pixel(100, 104);
    send_pixel(95, 100);
    settle();

    load_geometry(MODE_DISK, circle_word(-32768, -32768, 65535),
                  circle_word(32767, 32767, 65535), box_word(-32768, -32768, 32767, 32767),
                  box_word(32767, 32767, -32768, -32768), '1, 1'b0);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    settle();

    for (int ph = 0; ph < 24; ph++) begin
      ocx  = pick_center();
      ocy  = pick_center();
      orad = pick_radius();
      icx  = pick_center();
      icy  = pick_center();
      irad = pick_radius();
      if (ph == 8) begin
        orad = 0;
        irad = 0;
      end
      if (ph == 13) begin
        ocx  = -32768;
        ocy  = 32767;
        orad = 65535;
        icx  = 32767;
        icy  = -32768;
        irad = 65535;
      end
      pick_rects();
      if ($urandom_range(0, 2) != 0) begin
        icx = ocx;
        icy = ocy;
      end
      load_geometry(mode_e'(3'(ph % 7)), circle_word(ocx, ocy, orad),
                    circle_word(icx, icy, irad), box_word(rx0[0], ry0[0], rx1[0], ry1[0]),
                    box_word(rx0[1], ry0[1], rx1[1], ry1[1]),
                    box_word(rx0[2], ry0[2], rx1[2], ry1[2]), $urandom_range(0, 3) == 0);
      calm    = $urandom_range(0, 4) == 0;
      n_items = $urandom_range(60, 95);
      for (int k = 0; k < n_items; k++) begin
        choose_pixel(px, py);
        send_pixel(int'(px), int'(py));
        if (ph == 5 && k == n_items / 2) settle();
      end
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("** dial_region_mask_generator_unit: PASSED **");
    end else begin
      $display("** dial_region_mask_generator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("** dial_region_mask_generator_unit: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/drmg_pkg.sv
hw/rtl/drmg_cfg.sv
hw/rtl/drmg_front.sv
hw/rtl/drmg_decide.sv
hw/rtl/dial_region_mask_generator_unit.sv
hw/rtl/drmg_checker.sv
tb/sv/drmg_region_checker.sv
tb/sv/dial_region_mask_generator_unit_tb.sv
